[design/interference_graph_colouring_top_assert.svh]
// Assertion macros shared by the colouring block
`ifndef INTERFERENCE_GRAPH_COLOURING_TOP_ASSERT_SVH
`define INTERFERENCE_GRAPH_COLOURING_TOP_ASSERT_SVH
// Implication checked every clock, off during reset
`define IGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("igc assertion failed");
// Next-cycle implication, off during reset
`define IGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("igc assertion failed");
`endif

[design/igc_pkg.sv]
// -----------------------------------------------------------------------------
// igc_pkg
// Types, constants and commands of the interference graph colouring block.
// -----------------------------------------------------------------------------
`default_nettype none
package igc_pkg;
    localparam int MaxNodes = 32;
    localparam int PhysRegs = 16;
    localparam int NodeW = $clog2(MaxNodes);
    localparam int CntW = $clog2(MaxNodes + 1);
    localparam int ColW = $clog2(PhysRegs);
    localparam int DegW = $clog2(MaxNodes + PhysRegs + 1);
    localparam int PcW = $clog2(PhysRegs + 1);

    typedef enum logic [3:0] {
        t_ST_IDLE, t_ST_SIMP_START, t_ST_SIMP_SCAN, t_ST_SIMP_PUSH,
        t_ST_SEL_POP, t_ST_SEL_SCAN, t_ST_SEL_PICK, t_ST_OUT
    } t_state;

    typedef struct packed {
        logic load;        // write one row
        logic simp_init;   // remaining = present & count mask, depth = 0
        logic scan_clr;    // reset best, index to 0
        logic scan_step;   // examine node at index
        logic push;        // push best, clear remaining bit
        logic pop;         // pop top into current node
        logic pick;        // assign lowest free colour
        logic out_init;    // index 0 for output
        logic out_step;    // present result at index
    } t_cmd;

    typedef struct packed {
        logic remain_zero;
        logic scan_done;   // index reached count-1
        logic stack_empty;
        logic count_zero;
        logic out_last;
    } t_status;
endpackage
`default_nettype wire

[design/igc_datapath.sv]
// -----------------------------------------------------------------------------
// igc_datapath
// Adjacency storage, stack, degree scan, colour pick and result register.
// -----------------------------------------------------------------------------
`default_nettype none
`include "interference_graph_colouring_top_assert.svh"
module igc_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire igc_pkg::t_cmd               i_cmd,
    output igc_pkg::t_status                 o_status,
    input  wire logic [igc_pkg::NodeW-1:0]   i_node,
    input  wire logic                        i_present,
    input  wire logic [igc_pkg::MaxNodes-1:0] i_vn,
    input  wire logic [igc_pkg::PhysRegs-1:0] i_pc,
    input  wire logic [5:0]                  i_cfg_count,
    output logic [igc_pkg::NodeW-1:0]        o_node_index,
    output logic [igc_pkg::ColW-1:0]         o_colour,
    output logic                             o_valid_res,
    output logic                             o_spilled,
    output logic                             o_last
);
    localparam int N = igc_pkg::MaxNodes;
    localparam int P = igc_pkg::PhysRegs;

    logic [N-1:0] r_nrow [N];
    logic [P-1:0] r_prow [N];
    logic [igc_pkg::PcW-1:0] r_pcnt [N];
    logic [igc_pkg::NodeW-1:0] r_stack [N];
    logic [igc_pkg::ColW-1:0] r_col [N];
    logic [N-1:0] r_present, r_remain, r_alloc;
    logic [igc_pkg::CntW-1:0] r_depth;
    logic [igc_pkg::CntW-1:0] r_count;
    logic [N-1:0] r_cmask;
    logic [igc_pkg::NodeW-1:0] r_idx, r_best, r_cur;
    logic [igc_pkg::DegW-1:0] r_best_deg;
    logic r_best_ok;
    logic [P-1:0] r_blocked;

    logic [igc_pkg::CntW-1:0] w_count;
    logic [N-1:0] w_cmask, w_row;
    logic [igc_pkg::DegW-1:0] w_deg;
    logic w_free_found;
    logic [igc_pkg::ColW-1:0] w_free;

    always_comb begin
        if (i_cfg_count > 6'(N)) begin
            w_count = igc_pkg::CntW'(N);
        end else begin
            w_count = igc_pkg::CntW'(i_cfg_count);
        end
        for (int j = 0; j < N; j++) begin
            w_cmask[j] = (igc_pkg::CntW'(j) < w_count);
        end
    end

    // degree of node at scan index against current remaining set
    always_comb begin
        w_row = r_nrow[r_idx] & r_remain;
        w_row[r_idx] = 1'b0;
        w_deg = igc_pkg::DegW'($countones(w_row)) + igc_pkg::DegW'(r_pcnt[r_idx]);
    end

    always_comb begin
        w_free_found = 1'b0;
        w_free = '0;
        for (int c = P - 1; c >= 0; c--) begin
            if (!r_blocked[c]) begin
                w_free_found = 1'b1;
                w_free = igc_pkg::ColW'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_nrow[i_node] <= i_vn;
            r_prow[i_node] <= i_pc;
            r_pcnt[i_node] <= igc_pkg::PcW'($countones(i_pc));
        end
        if (i_cmd.push) begin
            r_stack[r_depth[igc_pkg::NodeW-1:0]] <= r_best;
        end
        if (i_cmd.pick && w_free_found) begin
            r_col[r_cur] <= w_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_remain <= '0;
            r_alloc <= '0;
            r_depth <= '0;
            o_valid_res <= 1'b0;
            o_spilled <= 1'b0;
            o_last <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_present[i_node] <= i_present;
            end
            if (i_cmd.simp_init) begin
                r_count <= w_count;
                r_cmask <= w_cmask;
                r_remain <= r_present & w_cmask;
                r_depth <= '0;
                r_alloc <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
                r_best_ok <= 1'b0;
                r_best <= '0;
                r_best_deg <= '1;
            end
            if (i_cmd.scan_step) begin
                // walk neighbours of current node during select, nodes during simplify
                if (r_remain[r_idx] && (!r_best_ok || w_deg < r_best_deg)) begin
                    r_best_ok <= 1'b1;
                    r_best <= r_idx;
                    r_best_deg <= w_deg;
                end
                if (r_nrow[r_cur][r_idx] && r_cmask[r_idx] && r_alloc[r_idx]) begin
                    r_blocked[r_col[r_idx]] <= 1'b1;
                end
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.push) begin
                r_depth <= r_depth + 1'b1;
                r_remain[r_best] <= 1'b0;
            end
            if (i_cmd.pop) begin
                r_cur <= r_stack[r_depth[igc_pkg::NodeW-1:0] - 1'b1];
                r_blocked <= r_prow[r_stack[r_depth[igc_pkg::NodeW-1:0] - 1'b1]];
                r_depth <= r_depth - 1'b1;
            end
            if (i_cmd.pick && w_free_found) begin
                r_alloc[r_cur] <= 1'b1;
            end
            if (i_cmd.out_init) begin
                r_idx <= '0;
            end
            if (i_cmd.out_step) begin
                o_node_index <= r_idx;
                o_colour <= r_alloc[r_idx] ? r_col[r_idx] : '0;
                o_valid_res <= r_alloc[r_idx];
                o_spilled <= r_present[r_idx] && !r_alloc[r_idx];
                o_last <= (igc_pkg::CntW'(r_idx) + 1'b1 == r_count);
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_status.remain_zero = (r_remain == '0);
    assign o_status.scan_done = (igc_pkg::CntW'(r_idx) + 1'b1 >= r_count);
    assign o_status.stack_empty = (r_depth == '0);
    assign o_status.count_zero = (w_count == '0);
    assign o_status.out_last = (igc_pkg::CntW'(r_idx) + 1'b1 == r_count);

    `IGC_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1,
        r_depth <= igc_pkg::CntW'(N))
    `IGC_ASSERT_NXT(a_push_clears, i_clk, i_rst_n, i_cmd.push, !r_remain[$past(r_best)])
    `IGC_ASSERT_IMP(a_pick_one, i_clk, i_rst_n, i_cmd.pick, !i_cmd.scan_step && !i_cmd.pop)
endmodule
`default_nettype wire

[design/igc_ctrl.sv]
// -----------------------------------------------------------------------------
// igc_ctrl
// Sequencer for load, simplify, select and result phases.
// -----------------------------------------------------------------------------
`default_nettype none
`include "interference_graph_colouring_top_assert.svh"
module igc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_fire,
    input  wire logic             i_mode,
    input  wire logic             i_out_free,
    input  wire igc_pkg::t_status i_status,
    output igc_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_load
);
    igc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= igc_pkg::t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            igc_pkg::t_ST_IDLE: begin
                if (i_in_fire && i_mode && !i_status.count_zero) begin
                    n_state = igc_pkg::t_ST_SIMP_START;
                end
            end
            igc_pkg::t_ST_SIMP_START: begin
                n_state = i_status.remain_zero ? igc_pkg::t_ST_SEL_POP
                                               : igc_pkg::t_ST_SIMP_SCAN;
            end
            igc_pkg::t_ST_SIMP_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = igc_pkg::t_ST_SIMP_PUSH;
                end
            end
            igc_pkg::t_ST_SIMP_PUSH: n_state = igc_pkg::t_ST_SIMP_START;
            igc_pkg::t_ST_SEL_POP: begin
                n_state = i_status.stack_empty ? igc_pkg::t_ST_OUT : igc_pkg::t_ST_SEL_SCAN;
            end
            igc_pkg::t_ST_SEL_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = igc_pkg::t_ST_SEL_PICK;
                end
            end
            igc_pkg::t_ST_SEL_PICK: n_state = igc_pkg::t_ST_SEL_POP;
            igc_pkg::t_ST_OUT: begin
                if (i_out_free && i_status.out_last) begin
                    n_state = igc_pkg::t_ST_IDLE;
                end
            end
            default: n_state = igc_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            igc_pkg::t_ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire && !i_mode;
                o_cmd.simp_init = i_in_fire && i_mode;
            end
            igc_pkg::t_ST_SIMP_START: o_cmd.scan_clr = !i_status.remain_zero;
            igc_pkg::t_ST_SIMP_SCAN: o_cmd.scan_step = 1'b1;
            igc_pkg::t_ST_SIMP_PUSH: o_cmd.push = 1'b1;
            igc_pkg::t_ST_SEL_POP: begin
                o_cmd.pop = !i_status.stack_empty;
                o_cmd.scan_clr = !i_status.stack_empty;
                o_cmd.out_init = i_status.stack_empty;
            end
            igc_pkg::t_ST_SEL_SCAN: o_cmd.scan_step = 1'b1;
            igc_pkg::t_ST_SEL_PICK: o_cmd.pick = 1'b1;
            igc_pkg::t_ST_OUT: begin
                o_cmd.out_step = i_out_free;
                o_out_load = i_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    `IGC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == igc_pkg::t_ST_IDLE)
    `IGC_ASSERT_NXT(a_run_starts, i_clk, i_rst_n,
        r_state == igc_pkg::t_ST_IDLE && i_in_fire && i_mode && !i_status.count_zero,
        r_state == igc_pkg::t_ST_SIMP_START)
    `IGC_ASSERT_IMP(a_out_only, i_clk, i_rst_n, o_out_load, r_state == igc_pkg::t_ST_OUT)
endmodule
`default_nettype wire

[design/interference_graph_colouring_top.sv]
// A run first simplifies the present nodes, then selects their colours, then
// presents the results in index order as the output register frees; a load writes one row.
// The single scan over node rows, one node per cycle, sets the rate.
// Only one item is worked on at a time; input is held off until the last result
// of a run is in the output register. Reset (synchronous, active low) clears
// presence bits and sets node_count to 32; adjacency rows are undefined until loaded.
// -----------------------------------------------------------------------------
// interference_graph_colouring_top
// Graph colouring register allocator with stream ports.
// -----------------------------------------------------------------------------
`default_nettype none
`include "interference_graph_colouring_top_assert.svh"
module interference_graph_colouring_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] node(5 at 0) present(1 at 5) virtual_neighbours(32 at 6)
    // physical_conflicts(16 at 38), zero pad to 56
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // node_index(5 at 0) colour(4 at 5) valid_res(1 at 9) spilled(1 at 10), pad to 16
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata
);
    logic [5:0] r_node_count;
    logic r_out_valid;
    logic w_in_fire, w_out_free, w_out_load;
    igc_pkg::t_cmd w_cmd;
    igc_pkg::t_status w_status;
    logic [igc_pkg::NodeW-1:0] w_idx;
    logic [igc_pkg::ColW-1:0] w_col;
    logic w_vr, w_sp, w_last;

    assign w_in_fire = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 6'd32;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    igc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire), .i_mode(s_axis_tuser),
        .i_out_free(w_out_free), .i_status(w_status), .o_cmd(w_cmd),
        .o_in_ready(s_axis_tready), .o_out_load(w_out_load)
    );

    igc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_node(s_axis_tdata[4:0]), .i_present(s_axis_tdata[5]),
        .i_vn(s_axis_tdata[37:6]), .i_pc(s_axis_tdata[53:38]),
        .i_cfg_count(r_node_count),
        .o_node_index(w_idx), .o_colour(w_col), .o_valid_res(w_vr),
        .o_spilled(w_sp), .o_last(w_last)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {5'd0, w_sp, w_vr, w_col, w_idx};
    assign m_axis_tlast = w_last;

    `IGC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `IGC_ASSERT_IMP(a_no_cfg_busy, i_clk, i_rst_n, i_cfg_we, s_axis_tready && !m_axis_tvalid)
    `IGC_ASSERT_IMP(a_ready_no_load, i_clk, i_rst_n, s_axis_tready, !w_out_load)
endmodule
`default_nettype wire
